// ----- hdl/bkat_pkg.sv -----
package bkat_pkg;

    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int BYTES_W  = 48;
    localparam int REQ_W    = 32;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_NEW         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COUNTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DECREMENTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // one table slot as stored in the RAM
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;   // write an empty slot at the sweep address
        logic fold;     // input beat taken
        logic scan;     // table scan in progress
        logic commit;   // update slot (when one applies) and load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/bkat_ram.sv -----
module bkat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bkat_ctrl.sv -----
module bkat_ctrl
    import bkat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_last_frame,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.fold = 1'b1;
                    if (i_last_frame) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/bkat_dp.sv -----
module bkat_dp
    import bkat_pkg::*;
#(
    parameter int FRAMES  = 8,
    parameter int ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_kind,
    input  logic [KEY_W-1:0]    i_frame_word,
    input  logic                i_last_frame,
    input  logic [REQ_W-1:0]    i_requested_bytes,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_site_key,
    output logic [COUNT_W-1:0]  o_site_count,
    output logic [BYTES_W-1:0]  o_site_bytes
);

    localparam int AW  = $clog2(ENTRIES);
    localparam int FIW = $clog2(FRAMES + 1);
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(ENTRIES - 1);
    localparam logic [FIW-1:0] FRAME_LIM  = FIW'(FRAMES);

    // fold state
    logic [KEY_W-1:0]   r_acc;
    logic [FIW-1:0]     r_idx;
    logic [KEY_W-1:0]   fold_next;

    // run under lookup
    logic [KEY_W-1:0]   r_key;
    logic               r_kind;
    logic [REQ_W-1:0]   r_req;

    // scan
    logic [AW-1:0]      r_addr;
    logic               r_issue;
    logic               r_chk;
    logic [AW-1:0]      r_chk_addr;
    logic               r_hit;
    logic [AW-1:0]      r_slot;
    logic [COUNT_W-1:0] r_hit_cnt;
    logic [BYTES_W-1:0] r_hit_bytes;
    logic               r_free;
    logic [AW-1:0]      r_free_slot;

    // result
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_out_key;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic [BYTES_W-1:0]  r_out_bytes;

    // RAM side
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    // update logic
    logic [COUNT_W-1:0]  cnt_inc;
    logic [COUNT_W-1:0]  cnt_dec;
    logic [BYTES_W:0]    byte_sum;
    logic [BYTES_W-1:0]  byte_sat;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_cnt;
    logic [BYTES_W-1:0]  res_bytes;
    logic                last_beat;

    assign fold_next = (r_idx < FRAME_LIM) ? (r_acc ^ i_frame_word) : r_acc;
    assign last_beat = i_cmd.fold && i_last_frame;
    assign rd_entry  = t_entry'(ram_rdata);

    assign cnt_inc  = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;
    assign cnt_dec  = r_hit_cnt - 1'b1;
    assign byte_sum = {1'b0, r_hit_bytes} + (BYTES_W + 1)'(r_req);
    assign byte_sat = byte_sum[BYTES_W] ? BYTES_MAX : byte_sum[BYTES_W-1:0];

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wentry = '0;
        res_status = ST_FULL;
        res_cnt    = '0;
        res_bytes  = '0;
        if (i_cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.commit) begin
            if (r_kind == KIND_ADD) begin
                if (r_hit) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_slot;
                    ram_wentry = '{valid: 1'b1, key: r_key, count: cnt_inc, bytes: byte_sat};
                    res_status = ST_COUNTED;
                    res_cnt    = cnt_inc;
                    res_bytes  = byte_sat;
                end else if (r_free) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_free_slot;
                    ram_wentry = '{valid: 1'b1, key: r_key, count: COUNT_W'(1),
                                   bytes: BYTES_W'(r_req)};
                    res_status = ST_NEW;
                    res_cnt    = COUNT_W'(1);
                    res_bytes  = BYTES_W'(r_req);
                end else begin
                    res_status = ST_FULL;
                end
            end else begin
                if (r_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_slot;
                    if (r_hit_cnt <= COUNT_W'(1)) begin
                        ram_wentry = '{valid: 1'b0, key: r_key, count: r_hit_cnt,
                                       bytes: r_hit_bytes};
                        res_status = ST_FREED;
                    end else begin
                        ram_wentry = '{valid: 1'b1, key: r_key, count: cnt_dec,
                                       bytes: r_hit_bytes};
                        res_status = ST_DECREMENTED;
                        res_cnt    = cnt_dec;
                        res_bytes  = r_hit_bytes;
                    end
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
        end
    end

    bkat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_idx       <= '0;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fold) begin
                if (i_last_frame) begin
                    r_acc <= '0;
                    r_idx <= '0;
                end else begin
                    r_acc <= fold_next;
                    if (r_idx < FRAME_LIM) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end

            if (i_cmd.clr_wr) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end else if (last_beat) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
                r_hit   <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.scan && r_issue) begin
                r_addr  <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
                r_issue <= (r_addr != LAST_ADDR);
            end

            r_chk <= i_cmd.scan && r_issue;

            if (r_chk) begin
                if (rd_entry.valid && rd_entry.key == r_key && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!rd_entry.valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (last_beat) begin
            r_key  <= fold_next;
            r_kind <= i_kind;
            r_req  <= i_requested_bytes;
        end
        r_chk_addr <= r_addr;
        if (r_chk) begin
            if (rd_entry.valid && rd_entry.key == r_key && !r_hit) begin
                r_slot      <= r_chk_addr;
                r_hit_cnt   <= rd_entry.count;
                r_hit_bytes <= rd_entry.bytes;
            end
            if (!rd_entry.valid && !r_free) begin
                r_free_slot <= r_chk_addr;
            end
        end
        if (i_cmd.commit) begin
            r_status    <= res_status;
            r_out_key   <= r_key;
            r_out_cnt   <= res_cnt;
            r_out_bytes <= res_bytes;
        end
    end

    assign o_stat.clear_last = (r_addr == LAST_ADDR);
    assign o_stat.scan_done  = !r_issue && !r_chk;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_site_key   = r_out_key;
    assign o_site_count = r_out_cnt;
    assign o_site_bytes = r_out_bytes;

endmodule

// ----- hdl/backtrace_keyed_allocation_tally_top.sv -----
// Input: a non-last frame beat does not stall the input; after a run's last beat the input
//   stays stalled through the scan, reading one slot per cycle from the slot RAM, and the commit.
// Result: valid once the last beat of a run has gone through scan, compare and update,
//   later if the output register is still held.
// Reset: synchronous, active low; after reset a sweep writes every slot empty,
//   input stalled meanwhile.
module backtrace_keyed_allocation_tally_top
    import bkat_pkg::*;
#(
    parameter int FRAMES  = 8,
    parameter int ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel: one frame word per beat
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [KEY_W-1:0]    i_frame_word,
    input  logic                i_last_frame,
    input  logic [REQ_W-1:0]    i_requested_bytes,
    // result channel: one beat per run
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_site_key,
    output logic [COUNT_W-1:0]  o_site_count,
    output logic [BYTES_W-1:0]  o_site_bytes
);

    // Controller sequences sweep / fold / scan / commit; the datapath
    // owns the fold accumulator, the slot RAM and the result register.
    t_cmd  cmd;
    t_stat stat;

    bkat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_frame (i_last_frame),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall)
    );

    // Scan keeps the first matching valid slot and the lowest empty slot;
    // the commit cycle applies add/remove with saturation and loads the
    // output register, which holds its beat until taken.
    bkat_dp #(
        .FRAMES  (FRAMES),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_kind            (i_kind),
        .i_frame_word      (i_frame_word),
        .i_last_frame      (i_last_frame),
        .i_requested_bytes (i_requested_bytes),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_site_key        (o_site_key),
        .o_site_count      (o_site_count),
        .o_site_bytes      (o_site_bytes)
    );

endmodule
